// ===== hdl/dfs_connected_components_unit_macros.svh =====
// Assertion macros for the checker of the connected components unit.
// Each macro places one labeled concurrent assertion on the rising edge of clk,
// disabled while arst_n is low.
`ifndef DFS_CONNECTED_COMPONENTS_UNIT_MACROS_SVH
`define DFS_CONNECTED_COMPONENTS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFSCC_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DFSCC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/dfs_cc_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_cc_pkg
// Shared types and constants of the depth-first connected components unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_cc_pkg;

	// Default sizes of the graph store.
	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF    = 256;

	// Fixed field widths of the stream payloads.
	localparam int ACTION_W   = 2;
	localparam int VERTEX_W   = 6;
	localparam int COUNT_W    = 7;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 16;

	// Action codes carried in the input tuser.
	typedef enum logic [ACTION_W-1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_RUN   = 2'd2
	} act_t;

	// Requests from the traversal engine to the result buffer.
	typedef struct packed {
		logic                emit;
		logic                mark_end;
		logic                finish;
		logic [VERTEX_W-1:0] vertex;
		logic [VERTEX_W-1:0] comp;
	} emit_req_t;

	// Status of the result buffer seen by the traversal engine.
	typedef struct packed {
		logic take_ok;
		logic flush_ok;
	} emit_stat_t;

endpackage

`default_nettype wire

// ===== hdl/dfs_cc_ram.sv =====
// ----------------------------------------------------------------------------
// dfs_cc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_cc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/dfs_cc_emit.sv =====
// ----------------------------------------------------------------------------
// dfs_cc_emit
// Result buffer: holds the newest vertex until its end flags are known, then
// moves it into the output register of the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_cc_emit import dfs_cc_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire emit_req_t           req,
	output      emit_stat_t          stat,
	output      logic                m_valid,
	input  wire logic                m_ready,
	output      logic [VERTEX_W-1:0] m_vertex,
	output      logic [VERTEX_W-1:0] m_comp,
	output      logic                m_lastc,
	output      logic                m_last
);

	logic                pend_v_q;
	logic [VERTEX_W-1:0] pend_vertex_q;
	logic [VERTEX_W-1:0] pend_comp_q;
	logic                pend_lastc_q;
	logic                out_v_q;
	logic [VERTEX_W-1:0] out_vertex_q;
	logic [VERTEX_W-1:0] out_comp_q;
	logic                out_lastc_q;
	logic                out_last_q;
	logic                can_move;
	logic                push;

	// The held vertex may move once the output register is free or draining.
	assign can_move      = pend_v_q && (!out_v_q || m_ready);
	assign push          = can_move && (req.emit || req.finish);
	assign stat.take_ok  = !pend_v_q || can_move;
	assign stat.flush_ok = !pend_v_q || can_move;

	// Valid flags of the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (push) begin
				out_v_q <= 1'b1;
			end else if (m_ready) begin
				out_v_q <= 1'b0;
			end
			if (req.emit) begin
				pend_v_q <= 1'b1;
			end else if (push) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Payload of the two stages.
	always_ff @(posedge clk) begin
		if (push) begin
			out_vertex_q <= pend_vertex_q;
			out_comp_q   <= pend_comp_q;
			out_lastc_q  <= pend_lastc_q;
			out_last_q   <= req.finish;
		end
		if (req.emit) begin
			pend_vertex_q <= req.vertex;
			pend_comp_q   <= req.comp;
			pend_lastc_q  <= 1'b0;
		end else if (req.mark_end) begin
			pend_lastc_q <= 1'b1;
		end
	end

	assign m_valid  = out_v_q;
	assign m_vertex = out_vertex_q;
	assign m_comp   = out_comp_q;
	assign m_lastc  = out_lastc_q;
	assign m_last   = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/dfs_cc_engine.sv =====
// ----------------------------------------------------------------------------
// dfs_cc_engine
// Graph store and traversal sequencer. Adjacency lists, list heads and tails
// and the traversal stack live in synchronous RAMs; a one-hot sequencer
// reads, updates and writes them back.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_cc_engine import dfs_cc_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire logic [ACTION_W-1:0] in_action,
	input  wire logic [VERTEX_W-1:0] in_source,
	input  wire logic [VERTEX_W-1:0] in_target,
	input  wire logic [COUNT_W-1:0]  in_count,
	output      emit_req_t           emit_req,
	input  wire emit_stat_t          emit_stat
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int DW = $clog2(MAX_VERTICES + 1);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int LW = EW + 1;
	localparam logic [LW-1:0]      END_CODE = LW'(MAX_EDGES);
	localparam logic [COUNT_W-1:0] MV_C     = COUNT_W'(MAX_VERTICES);
	localparam logic [DW-1:0]      MV_D     = DW'(MAX_VERTICES);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_ADD_LINK = 8'b0000_0010,
		ST_START    = 8'b0000_0100,
		ST_PUSH     = 8'b0000_1000,
		ST_LOOP     = 8'b0001_0000,
		ST_CUR      = 8'b0010_0000,
		ST_EDGE     = 8'b0100_0000,
		ST_FINISH   = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [LW-1:0]       total_q;
	logic [MAX_VERTICES-1:0] head_valid_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [DW-1:0]       limit_q;
	logic [DW-1:0]       start_q;
	logic [DW-1:0]       depth_q;
	logic [VW-1:0]       comp_q;
	logic [VW-1:0]       src_q;
	logic                hv_q;

	logic                accept;
	logic                add_go;
	logic                first;
	logic [VW-1:0]       src_v;
	logic [DW-1:0]       depth_m1;
	logic [VW-1:0]       top_idx;
	logic [VW-1:0]       start_v;
	logic                at_end;
	logic                visit_start;
	logic                visit_edge;
	logic                visit_want;
	logic                visit_go;
	logic [VW-1:0]       visit_v;
	logic                cur_end;
	logic                edge_leave;

	// RAM ports.
	logic                head_we, head_re;
	logic [VW-1:0]       head_waddr, head_raddr;
	logic [EW-1:0]       head_wdata, head_rd;
	logic                tail_we, tail_re;
	logic [VW-1:0]       tail_waddr, tail_raddr;
	logic [EW-1:0]       tail_wdata, tail_rd;
	logic                dest_we, edge_re;
	logic [EW-1:0]       dest_waddr, edge_raddr;
	logic [VW-1:0]       dest_wdata, dest_rd;
	logic                link_we;
	logic [EW-1:0]       link_waddr;
	logic [LW-1:0]       link_wdata, link_rd;
	logic                stack_we, stack_re;
	logic [VW-1:0]       stack_waddr, stack_raddr;
	logic [LW-1:0]       stack_wdata, stack_rd;

	// Input decode and traversal conditions.
	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign src_v       = in_source[VW-1:0];
	assign first       = !head_valid_q[src_v];
	assign add_go      = accept && (in_action == ACT_ADD)
	                     && ({1'b0, in_source} < MV_C) && ({1'b0, in_target} < MV_C)
	                     && (total_q != END_CODE);
	assign depth_m1    = depth_q - DW'(1);
	assign top_idx     = depth_m1[VW-1:0];
	assign start_v     = start_q[VW-1:0];
	assign at_end      = (start_q == limit_q);
	assign cur_end     = (stack_rd == END_CODE);
	assign visit_start = (state_q == ST_START) && !at_end && !visited_q[start_v];
	assign visit_edge  = (state_q == ST_EDGE) && !visited_q[dest_rd];
	assign visit_want  = visit_start || visit_edge;
	assign visit_go    = visit_want && emit_stat.take_ok;
	assign visit_v     = (state_q == ST_START) ? start_v : dest_rd;
	assign edge_leave  = (state_q == ST_EDGE) && (!visit_edge || visit_go);

	// Requests to the result buffer.
	assign emit_req.emit     = visit_go;
	assign emit_req.mark_end = (state_q == ST_LOOP) && (depth_q == '0);
	assign emit_req.finish   = (state_q == ST_FINISH);
	assign emit_req.vertex   = VERTEX_W'(visit_v);
	assign emit_req.comp     = VERTEX_W'(comp_q);

	// RAM access steering.
	always_comb begin
		head_we     = add_go && first;
		head_waddr  = src_v;
		head_wdata  = total_q[EW-1:0];
		head_re     = visit_go;
		head_raddr  = visit_v;

		tail_we     = (add_go && first) || (state_q == ST_ADD_LINK);
		tail_waddr  = (state_q == ST_ADD_LINK) ? src_q : src_v;
		tail_wdata  = total_q[EW-1:0];
		tail_re     = add_go;
		tail_raddr  = src_v;

		dest_we     = add_go;
		dest_waddr  = total_q[EW-1:0];
		dest_wdata  = in_target[VW-1:0];
		edge_re     = (state_q == ST_CUR) && !cur_end;
		edge_raddr  = stack_rd[EW-1:0];

		link_we     = add_go || (state_q == ST_ADD_LINK);
		link_waddr  = (state_q == ST_ADD_LINK) ? tail_rd : total_q[EW-1:0];
		link_wdata  = (state_q == ST_ADD_LINK) ? total_q : END_CODE;

		stack_we    = (state_q == ST_PUSH) || edge_leave;
		stack_waddr = (state_q == ST_PUSH) ? depth_q[VW-1:0] : top_idx;
		stack_wdata = (state_q == ST_PUSH) ? (hv_q ? {1'b0, head_rd} : END_CODE) : link_rd;
		stack_re    = (state_q == ST_LOOP) && (depth_q != '0);
		stack_raddr = top_idx;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			total_q      <= '0;
			head_valid_q <= '0;
			visited_q    <= '0;
			limit_q      <= '0;
			start_q      <= '0;
			depth_q      <= '0;
			comp_q       <= '0;
			src_q        <= '0;
			hv_q         <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_action)
							ACT_CLEAR: begin
								head_valid_q <= '0;
								total_q      <= '0;
							end
							ACT_ADD: begin
								if (add_go) begin
									if (first) begin
										head_valid_q[src_v] <= 1'b1;
										total_q             <= total_q + LW'(1);
									end else begin
										src_q   <= src_v;
										state_q <= ST_ADD_LINK;
									end
								end
							end
							ACT_RUN: begin
								visited_q <= '0;
								comp_q    <= '0;
								depth_q   <= '0;
								start_q   <= '0;
								limit_q   <= (in_count > MV_C) ? MV_D : in_count[DW-1:0];
								state_q   <= ST_START;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADD_LINK: begin
					total_q <= total_q + LW'(1);
					state_q <= ST_IDLE;
				end
				ST_START: begin
					if (at_end) begin
						state_q <= ST_FINISH;
					end else if (visited_q[start_v]) begin
						start_q <= start_q + DW'(1);
					end else if (visit_go) begin
						visited_q[start_v] <= 1'b1;
						hv_q               <= head_valid_q[start_v];
						state_q            <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					depth_q <= depth_q + DW'(1);
					state_q <= ST_LOOP;
				end
				ST_LOOP: begin
					if (depth_q == '0) begin
						comp_q  <= comp_q + VW'(1);
						start_q <= start_q + DW'(1);
						state_q <= ST_START;
					end else begin
						state_q <= ST_CUR;
					end
				end
				ST_CUR: begin
					if (cur_end) begin
						depth_q <= depth_m1;
						state_q <= ST_LOOP;
					end else begin
						state_q <= ST_EDGE;
					end
				end
				ST_EDGE: begin
					if (!visit_edge) begin
						state_q <= ST_LOOP;
					end else if (visit_go) begin
						visited_q[dest_rd] <= 1'b1;
						hv_q               <= head_valid_q[dest_rd];
						state_q            <= ST_PUSH;
					end
				end
				ST_FINISH: begin
					if (emit_stat.flush_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// First edge of each list.
	dfs_cc_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.re(head_re), .raddr(head_raddr), .rdata(head_rd)
	);

	// Last edge of each list.
	dfs_cc_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_tail (
		.clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
		.re(tail_re), .raddr(tail_raddr), .rdata(tail_rd)
	);

	// Destination of each edge.
	dfs_cc_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_dest (
		.clk(clk), .we(dest_we), .waddr(dest_waddr), .wdata(dest_wdata),
		.re(edge_re), .raddr(edge_raddr), .rdata(dest_rd)
	);

	// Next edge in the same list.
	dfs_cc_ram #(.WIDTH(LW), .DEPTH(MAX_EDGES)) u_link (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.re(edge_re), .raddr(edge_raddr), .rdata(link_rd)
	);

	// List cursor of each vertex on the traversal stack.
	dfs_cc_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_stack (
		.clk(clk), .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
		.re(stack_re), .raddr(stack_raddr), .rdata(stack_rd)
	);

endmodule

`default_nettype wire

// ===== hdl/dfs_connected_components_unit.sv =====
// Depth-first connected components unit. Each input transaction carries an
// action in tuser: clear the graph, append one directed edge, or run a
// traversal over start vertices 0 to vertex_count-1 that returns every vertex
// reached in preorder with its component index. An add whose source already
// has edges also reads and links that source's list tail. The sequencer makes
// one step per cycle while the result buffer can take its requests: each edge
// costs a stack read, an edge read and a cursor write-back, each vertex costs
// a push and a final stack read and pop, each component is closed in ST_LOOP,
// and each start vertex is tried in ST_START, which also sees the end of the
// start range; ST_FINISH flushes the last result. Each result is held back
// until the next vertex is found or the run finishes, since its end flags are
// only known then. The input is ready only between transactions.
// ----------------------------------------------------------------------------
// dfs_connected_components_unit
// Top level: stream ports, traversal engine and result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_connected_components_unit import dfs_cc_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output      logic                 s_axis_tready,
	// source [5:0], target [11:6], vertex_count [18:12], zero [23:19]
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
	// action [1:0]
	input  wire logic [ACTION_W-1:0]  s_axis_tuser,
	output      logic                 m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// vertex [5:0], component_index [11:6], zero [15:12]
	output      logic [M_TDATA_W-1:0] m_axis_tdata,
	// last (end of the traversal run)
	output      logic                 m_axis_tlast,
	// last_of_component [0]
	output      logic [0:0]           m_axis_tuser
);

	emit_req_t           emit_req;
	emit_stat_t          emit_stat;
	logic [VERTEX_W-1:0] out_vertex;
	logic [VERTEX_W-1:0] out_comp;
	logic                out_lastc;

	dfs_cc_engine #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES   (MAX_EDGES)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_action(s_axis_tuser),
		.in_source(s_axis_tdata[VERTEX_W-1:0]),
		.in_target(s_axis_tdata[2*VERTEX_W-1:VERTEX_W]),
		.in_count (s_axis_tdata[2*VERTEX_W+COUNT_W-1:2*VERTEX_W]),
		.emit_req (emit_req),
		.emit_stat(emit_stat)
	);

	dfs_cc_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (emit_req),
		.stat    (emit_stat),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_vertex(out_vertex),
		.m_comp  (out_comp),
		.m_lastc (out_lastc),
		.m_last  (m_axis_tlast)
	);

	// Pack the result fields onto the master stream.
	assign m_axis_tdata    = M_TDATA_W'({out_comp, out_vertex});
	assign m_axis_tuser[0] = out_lastc;

endmodule

`default_nettype wire

// ===== hdl/dfs_cc_checker.sv =====
// ----------------------------------------------------------------------------
// dfs_cc_checker
// Port-level checks of the connected components unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dfs_connected_components_unit_macros.svh"

module dfs_cc_checker import dfs_cc_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_axis_tvalid,
	input wire logic                 s_axis_tready,
	input wire logic [ACTION_W-1:0]  s_axis_tuser,
	input wire logic                 m_axis_tvalid,
	input wire logic                 m_axis_tready,
	input wire logic [M_TDATA_W-1:0] m_axis_tdata,
	input wire logic                 m_axis_tlast,
	input wire logic [0:0]           m_axis_tuser
);

	logic in_xfer;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// A stalled result transaction keeps its contents.
	`DFSCC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
		&& $stable(m_axis_tuser), "stalled result changed")

	// The final result of a run also closes its component.
	`DFSCC_ASSERT_SAME(a_last_ends_comp, m_axis_tvalid && m_axis_tlast,
		m_axis_tuser[0], "run ended without closing its component")

	// A run keeps the input closed while the search starts.
	`DFSCC_ASSERT_NEXT(a_run_busy, in_xfer && (s_axis_tuser == ACT_RUN),
		!s_axis_tready, "input open right after a run was taken")

	// A clear leaves the input ready in the following cycle.
	`DFSCC_ASSERT_NEXT(a_clear_quick, in_xfer && (s_axis_tuser == ACT_CLEAR),
		s_axis_tready, "input closed after a clear")

endmodule

bind dfs_connected_components_unit dfs_cc_checker u_dfs_cc_checker (.*);

`default_nettype wire

// ===== dv/tb_dfs_connected_components_unit.sv =====
// ----------------------------------------------------------------------------
// tb_dfs_connected_components_unit
// Self-checking bench for the depth-first connected components unit. Commands
// (clear, add edge, traverse, and the unused code) go in on the input stream.
// A predictor keeps its own edge store and walks it in preorder for each
// traversal. Every result on the output stream is checked against the oldest
// expected visit. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_dfs_connected_components_unit;
	import dfs_cc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          VERTEX_SLOTS = MAX_VERTICES_DEF;
	localparam int          EDGE_SLOTS   = MAX_EDGES_DEF;
	localparam logic [1:0]  ACT_UNUSED   = 2'd3;
	localparam int unsigned QUIET_LIMIT  = 6000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned RANDOM_ITEMS = 20;
	localparam int unsigned REPORT_CAP   = 50;

	// One command on the input stream.
	typedef struct packed {
		logic [1:0]          action;
		logic [VERTEX_W-1:0] source;
		logic [VERTEX_W-1:0] target;
		logic [COUNT_W-1:0]  vertex_count;
	} graph_command_t;

	// One visited vertex as reported on the output stream.
	typedef struct packed {
		logic [VERTEX_W-1:0] vertex;
		logic [VERTEX_W-1:0] component;
		logic                end_of_component;
		logic                end_of_run;
	} visit_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [ACTION_W-1:0]  s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tlast;
	logic [0:0]           m_axis_tuser;

	graph_command_t pending_commands[$];
	visit_t         expected_visits[$];

	// Predictor copy of the edge store, kept in insertion order.
	logic [VERTEX_W-1:0] edge_from [EDGE_SLOTS];
	logic [VERTEX_W-1:0] edge_to [EDGE_SLOTS];
	int unsigned         stored_edges = 0;

	int unsigned commands_total = 0;
	int unsigned commands_taken = 0;
	int unsigned results_seen = 0;
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;
	logic        input_taken = 1'b0;
	bit          calm_input = 1'b0;
	bit          calm_output = 1'b0;
	int unsigned input_gap = 0;
	int unsigned output_stall = 0;
	int unsigned hold_left = 0;
	int unsigned next_hold_at = 30;

	dfs_connected_components_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_command(input logic [1:0] action, input int unsigned source,
			input int unsigned target, input int unsigned vertex_count);
		graph_command_t cmd;
		cmd.action       = action;
		cmd.source       = VERTEX_W'(source);
		cmd.target       = VERTEX_W'(target);
		cmd.vertex_count = COUNT_W'(vertex_count);
		pending_commands.insert(pending_commands.size(), cmd);
	endtask

	// Depth-first walk over the predictor's edge store. Neighbors of a vertex are
	// found by scanning the store in insertion order from a per-level position.
	task automatic predict_traversal(input logic [COUNT_W-1:0] start_count);
		logic [VERTEX_W-1:0] path_vertex [VERTEX_SLOTS];
		int unsigned         path_scan [VERTEX_SLOTS];
		bit                  reached [VERTEX_SLOTS];
		visit_t              run_visits[$];
		int unsigned         limit;
		int unsigned         depth;
		int unsigned         component;
		int unsigned         scan;
		logic [VERTEX_W-1:0] next_vertex;
		limit = (start_count > VERTEX_SLOTS) ? VERTEX_SLOTS : start_count;
		component = 0;
		for (int v = 0; v < VERTEX_SLOTS; v++) reached[v] = 1'b0;
		for (int start = 0; start < limit; start++) begin
			if (!reached[start]) begin
				reached[start] = 1'b1;
				run_visits.insert(run_visits.size(),
					'{VERTEX_W'(start), VERTEX_W'(component), 1'b0, 1'b0});
				path_vertex[0] = VERTEX_W'(start);
				path_scan[0] = 0;
				depth = 1;
				while (depth > 0) begin
					scan = path_scan[depth-1];
					while (scan < stored_edges && edge_from[scan] != path_vertex[depth-1])
						scan++;
					if (scan >= stored_edges) begin
						depth--;
					end else begin
						path_scan[depth-1] = scan + 1;
						next_vertex = edge_to[scan];
						if (!reached[next_vertex]) begin
							reached[next_vertex] = 1'b1;
							run_visits.insert(run_visits.size(),
								'{next_vertex, VERTEX_W'(component), 1'b0, 1'b0});
							path_vertex[depth] = next_vertex;
							path_scan[depth] = 0;
							depth++;
						end
					end
				end
				run_visits[run_visits.size()-1].end_of_component = 1'b1;
				component++;
			end
		end
		if (run_visits.size() != 0) run_visits[run_visits.size()-1].end_of_run = 1'b1;
		foreach (run_visits[i]) expected_visits.insert(expected_visits.size(), run_visits[i]);
	endtask

	// Apply one accepted command to the predictor.
	task automatic apply_command(input logic [ACTION_W-1:0] action,
			input logic [S_TDATA_W-1:0] payload);
		case (action)
			ACT_CLEAR: begin
				stored_edges = 0;
			end
			ACT_ADD: begin
				// A full store drops the edge.
				if (stored_edges < EDGE_SLOTS) begin
					edge_from[stored_edges] = payload[5:0];
					edge_to[stored_edges] = payload[11:6];
					stored_edges++;
				end
			end
			ACT_RUN: begin
				predict_traversal(payload[18:12]);
			end
			default: begin
				// The unused action code has no effect.
			end
		endcase
	endtask

	// Input driver: presents the next command once the current one is taken.
	always @(negedge clk) begin : command_driver
		graph_command_t cmd;
		if (arst_n && (!s_axis_tvalid || input_taken)) begin
			if (input_gap > 0) begin
				input_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_commands.size() != 0) begin
				cmd = pending_commands.pop_front();
				s_axis_tdata <= {5'b0, cmd.vertex_count, cmd.target, cmd.source};
				s_axis_tuser <= cmd.action;
				s_axis_tvalid <= 1'b1;
				if ($urandom_range(0, 29) == 0) calm_input = !calm_input;
				input_gap = calm_input ? 0 : pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Output ready: random stalls, calm stretches, and a few long hold-offs that
	// let the unit back up into its input.
	always @(negedge clk) begin : result_receiver
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (results_seen >= next_hold_at && m_axis_tvalid) begin
				hold_left = $urandom_range(200, 400);
				next_hold_at = next_hold_at + 700;
				m_axis_tready <= 1'b0;
			end else if (output_stall > 0) begin
				output_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				if ($urandom_range(0, 63) == 0) calm_output = !calm_output;
				if (!calm_output && $urandom_range(0, 3) == 0) output_stall = pick_gap();
				m_axis_tready <= (output_stall == 0);
			end
		end
	end

	// Monitor: feeds accepted commands to the predictor and checks results.
	always @(posedge clk) begin : stream_monitor
		visit_t got;
		visit_t want;
		input_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_command(s_axis_tuser, s_axis_tdata);
				commands_taken++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tuser[0], m_axis_tlast};
				results_seen++;
				if (expected_visits.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_CAP)
						$display("%0t: unexpected result vertex=%0d comp=%0d eoc=%b last=%b",
							$realtime, got.vertex, got.component,
							got.end_of_component, got.end_of_run);
				end else begin
					want = expected_visits.pop_front();
					if (got !== want) begin
						error_count++;
						if (error_count <= REPORT_CAP)
							$display("%0t: mismatch expected vertex=%0d comp=%0d eoc=%b last=%b, %s",
								$realtime, want.vertex, want.component, want.end_of_component,
								want.end_of_run, $sformatf("got vertex=%0d comp=%0d eoc=%b last=%b",
								got.vertex, got.component, got.end_of_component, got.end_of_run));
					end
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("tb_dfs_connected_components_unit: errors");
		$finish;
	end

	initial begin : stimulus
		int unsigned         order [VERTEX_SLOTS];
		int unsigned         swap_at;
		int unsigned         swap_val;
		int unsigned         span;
		int unsigned         adds;
		int unsigned         runs;
		int unsigned         roll;
		int unsigned         count;
		int unsigned         random_base;

		// Directed: empty graph runs, extremes, self loops, duplicates, vertices
		// reached beyond the start count, the unused action, and saturation.
		queue_command(ACT_RUN, 0, 0, 0);
		queue_command(ACT_RUN, 63, 63, 64);
		queue_command(ACT_RUN, 0, 0, 127);
		queue_command(ACT_UNUSED, 63, 63, 127);
		queue_command(ACT_ADD, 0, 63, 0);
		queue_command(ACT_ADD, 0, 0, 127);
		queue_command(ACT_ADD, 63, 0, 0);
		queue_command(ACT_ADD, 0, 63, 0);
		queue_command(ACT_ADD, 5, 63, 0);
		queue_command(ACT_ADD, 63, 63, 0);
		queue_command(ACT_RUN, 42, 21, 1);
		queue_command(ACT_RUN, 0, 0, 6);
		queue_command(ACT_UNUSED, 0, 0, 0);
		queue_command(ACT_RUN, 0, 0, 100);
		queue_command(ACT_CLEAR, 63, 63, 127);
		queue_command(ACT_RUN, 0, 0, 64);
		queue_command(ACT_ADD, 63, 62, 0);
		queue_command(ACT_ADD, 62, 1, 0);
		queue_command(ACT_RUN, 0, 0, 64);
		queue_command(ACT_RUN, 0, 0, 1);
		queue_command(ACT_CLEAR, 0, 0, 0);

		// Fill the store past capacity: a chain through all vertices for the
		// deepest stack, then random edges until later ones are dropped.
		for (int i = 0; i < VERTEX_SLOTS; i++) order[i] = i;
		for (int i = VERTEX_SLOTS - 1; i > 0; i--) begin
			swap_at = $urandom_range(0, i);
			swap_val = order[i];
			order[i] = order[swap_at];
			order[swap_at] = swap_val;
		end
		for (int i = 0; i < VERTEX_SLOTS - 1; i++)
			queue_command(ACT_ADD, order[i], order[i+1], $urandom_range(0, 127));
		for (int i = 0; i < EDGE_SLOTS - VERTEX_SLOTS + 7; i++)
			queue_command(ACT_ADD, $urandom_range(0, 63), $urandom_range(0, 63), 0);
		queue_command(ACT_RUN, 0, 0, 64);
		queue_command(ACT_RUN, $urandom_range(0, 63), $urandom_range(0, 63), 127);
		queue_command(ACT_RUN, 0, 0, $urandom_range(1, 63));

		// Random: clear now and then, build a graph over a vertex span, run it.
		random_base = pending_commands.size();
		while (pending_commands.size() - random_base < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0)
				queue_command(ACT_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 127));
			roll = $urandom_range(0, 99);
			span = (roll < 50) ? $urandom_range(1, 7) :
				(roll < 85) ? $urandom_range(8, 31) : $urandom_range(32, 63);
			adds = ($urandom_range(0, 6) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			for (int i = 0; i < adds; i++) begin
				if ($urandom_range(0, 19) == 0)
					queue_command(ACT_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 127));
				if ($urandom_range(0, 9) == 0)
					queue_command(ACT_ADD, $urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 127));
				else
					queue_command(ACT_ADD, $urandom_range(0, span), $urandom_range(0, span),
						$urandom_range(0, 127));
			end
			runs = $urandom_range(1, 2);
			for (int i = 0; i < runs; i++) begin
				roll = $urandom_range(0, 9);
				count = (roll < 7) ? $urandom_range(0, span + 1) :
					(roll < 9) ? $urandom_range(0, 64) : $urandom_range(65, 127);
				queue_command(ACT_RUN, $urandom_range(0, 63), $urandom_range(0, 63), count);
			end
		end
		commands_total = pending_commands.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (commands_taken != commands_total || expected_visits.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("tb_dfs_connected_components_unit: clean");
		else
			$display("tb_dfs_connected_components_unit: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/dfs_cc_pkg.sv
hdl/dfs_cc_ram.sv
hdl/dfs_cc_emit.sv
hdl/dfs_cc_engine.sv
hdl/dfs_connected_components_unit.sv
hdl/dfs_cc_checker.sv
dv/tb_dfs_connected_components_unit.sv
